// ===== rtl/core/periodic_timed_event_queue_assert.svh =====
// Assertion macros for the timed event queue
`ifndef PERIODIC_TIMED_EVENT_QUEUE_ASSERT_SVH
`define PERIODIC_TIMED_EVENT_QUEUE_ASSERT_SVH
`define PTEQ_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PTEQ_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/pteq_pkg.sv =====
// Package: sizes, command codes and state type for the timed event queue
package pteq_pkg;
    localparam int SLOTS     = 16;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ID_BITS   = 16;
    localparam int TIME_BITS = 32;
    localparam int MAX_FIRES = 64;
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SCHED  = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_LAST  = 5'b00100,
        ST_ACT   = 5'b01000,
        ST_WAIT  = 5'b10000
    } t_state;
endpackage

// ===== rtl/core/periodic_timed_event_queue.sv =====
// Top level: timed event queue with slot memory and a sequential scanner
//
// channel  | direction | handshake          | payload
// command  | in        | i_start / o_busy   | i_command i_event_id i_event_time i_event_interval
// result   | out       | o_strobe           | o_fired_valid o_fired_id o_found o_overflow o_last
//
// Check and remove scan all SLOTS entries, one read a cycle, then act. Schedule skips the scan.
// A tick with k firings scans k+1 times, or MAX_FIRES times when the fire cap is reached.
// A firing is held one scan so that the final one carries o_last; at the cap the final
// result follows in the first idle cycle. The registered memory read sets the scan pace.
// Reset clears the counter and used bits at once; slot contents need none.
// The receiver cannot stall.
module periodic_timed_event_queue
    import pteq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_command,
    input  logic [ID_BITS-1:0]   i_event_id,
    input  logic [TIME_BITS-1:0] i_event_time,
    input  logic [TIME_BITS-1:0] i_event_interval,
    output logic                 o_strobe,
    output logic                 o_fired_valid,
    output logic [ID_BITS-1:0]   o_fired_id,
    output logic                 o_found,
    output logic                 o_overflow,
    output logic                 o_last
);
`include "periodic_timed_event_queue_assert.svh"

    localparam int ENT_W = ID_BITS + 2 * TIME_BITS;

    logic [ENT_W-1:0] mem [SLOTS];
    logic [ENT_W-1:0] r_rd;
    logic [SLOTS-1:0] r_used, n_used;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_time, r_iv, r_now;
    logic [SLOT_W:0]      r_ra;
    logic [SLOT_W-1:0]    r_rs;
    logic                 r_rv;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_best;
    logic [TIME_BITS-1:0] r_bdue, r_breload;
    logic [ID_BITS-1:0]   r_bid;
    logic [FIRE_W-1:0]    r_nf;
    logic                 r_pend, n_pend;
    logic [ID_BITS-1:0]   r_pid, n_pid;

    logic                 n_strobe, n_fv, n_found, n_ovf, n_last;
    logic [ID_BITS-1:0]   n_fid;

    logic                 we;
    logic [SLOT_W-1:0]    wa;
    logic [ENT_W-1:0]     wd;
    logic [TIME_BITS-1:0] reload_due;

    logic [ID_BITS-1:0]   e_id;
    logic [TIME_BITS-1:0] e_due, e_rel;
    logic                 cand;
    logic [SLOT_W-1:0]    free_s;
    logic                 free_ok;
    logic                 accept;
    logic                 tick_hit;

    assign e_id  = r_rd[ENT_W-1 -: ID_BITS];
    assign e_due = r_rd[2*TIME_BITS-1 -: TIME_BITS];
    assign e_rel = r_rd[TIME_BITS-1:0];

    assign accept     = (r_state == ST_IDLE) && i_start;
    assign tick_hit   = (r_state == ST_ACT) && (r_cmd == CMD_TICK) && r_hit;
    assign reload_due = r_bdue + r_breload;

    always_comb begin
        cand = r_rv && r_used[r_rs];
        unique case (r_cmd)
            CMD_TICK: cand = cand && (e_due <= r_now);
            default:  cand = cand && (e_id == r_id);
        endcase
    end

    always_comb begin
        free_s  = '0;
        free_ok = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_s  = SLOT_W'(i);
                free_ok = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[r_ra[SLOT_W-1:0]];
    end

    assign o_busy = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = (t_cmd'(i_command) == CMD_SCHED) ? ST_ACT : ST_SCAN;
            ST_SCAN: if (r_ra == (SLOT_W+1)'(SLOTS - 1)) n_state = ST_LAST;
            ST_LAST: n_state = ST_ACT;
            ST_ACT:  n_state = (tick_hit && r_nf != FIRE_W'(MAX_FIRES - 1)) ? ST_SCAN : ST_WAIT;
            ST_WAIT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        we = 1'b0;
        wa = r_best;
        wd = {r_bid, reload_due, r_breload};
        if (r_state == ST_ACT && r_cmd == CMD_SCHED && r_id != '0 && free_ok) begin
            we = 1'b1;
            wa = free_s;
            wd = {r_id, r_time, r_iv};
        end else if (tick_hit && r_breload != '0) begin
            we = 1'b1;
        end
    end

    always_comb begin
        n_used = r_used;
        if (r_state == ST_ACT) begin
            if (r_cmd == CMD_SCHED && r_id != '0 && free_ok) begin
                n_used[free_s] = 1'b1;
            end else if (r_cmd == CMD_REMOVE && r_id != '0 && r_hit) begin
                n_used[r_best] = 1'b0;
            end else if (tick_hit && r_breload == '0) begin
                n_used[r_best] = 1'b0;
            end
        end
    end

    // a firing waits in r_pid until the next scan shows whether another follows
    always_comb begin
        n_strobe = 1'b0;
        n_fv     = 1'b0;
        n_fid    = '0;
        n_found  = 1'b0;
        n_ovf    = 1'b0;
        n_last   = 1'b0;
        n_pend   = r_pend;
        n_pid    = r_pid;
        if (r_state == ST_ACT) begin
            unique case (r_cmd)
                CMD_SCHED: begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_ovf    = (r_id != '0) && !free_ok;
                end
                CMD_CHECK: begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_found  = (r_id != '0) && r_hit;
                end
                CMD_REMOVE: begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                end
                CMD_TICK: begin
                    n_fv  = r_pend;
                    n_fid = r_pend ? r_pid : '0;
                    if (r_hit) begin
                        n_strobe = r_pend;
                        n_pend   = 1'b1;
                        n_pid    = r_bid;
                    end else begin
                        n_strobe = 1'b1;
                        n_last   = 1'b1;
                        n_pend   = 1'b0;
                    end
                end
                default: ;
            endcase
        end else if (r_state == ST_WAIT && r_pend) begin
            n_strobe = 1'b1;
            n_last   = 1'b1;
            n_fv     = 1'b1;
            n_fid    = r_pid;
            n_pend   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_used        <= '0;
            r_now         <= '0;
            r_cmd         <= CMD_TICK;
            r_rv          <= 1'b0;
            r_pend        <= 1'b0;
            o_strobe      <= 1'b0;
            o_fired_valid <= 1'b0;
            o_fired_id    <= '0;
            o_found       <= 1'b0;
            o_overflow    <= 1'b0;
            o_last        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_used        <= n_used;
            r_rv          <= (r_state == ST_SCAN);
            r_rs          <= r_ra[SLOT_W-1:0];
            r_pend        <= n_pend;
            r_pid         <= n_pid;
            o_strobe      <= n_strobe;
            o_fired_valid <= n_fv;
            o_fired_id    <= n_fid;
            o_found       <= n_found;
            o_overflow    <= n_ovf;
            o_last        <= n_last;
            if (accept) begin
                r_cmd  <= t_cmd'(i_command);
                r_id   <= i_event_id;
                r_time <= i_event_time;
                r_iv   <= i_event_interval;
                if (t_cmd'(i_command) == CMD_TICK) r_now <= r_now + 1'b1;
            end
            if (accept || tick_hit) begin
                r_ra <= '0;
            end else if (r_state == ST_SCAN) begin
                r_ra <= r_ra + 1'b1;
            end
            if (accept) begin
                r_nf <= '0;
            end else if (tick_hit) begin
                r_nf <= r_nf + 1'b1;
            end
            if (accept || r_state == ST_ACT) begin
                r_hit <= 1'b0;
            end else if (cand && (!r_hit || e_due < r_bdue)) begin
                r_hit <= 1'b1;
            end
            if (cand && (!r_hit || e_due < r_bdue)) begin
                r_best    <= r_rs;
                r_bdue    <= e_due;
                r_breload <= e_rel;
                r_bid     <= e_id;
            end
        end
    end

    `PTEQ_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe && !o_last, o_busy)
    `PTEQ_ASSERT_IMP(a_fire_not_found, i_clk, i_rst_n, o_strobe && o_fired_valid,
        !o_found && !o_overflow)
    `PTEQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)

endmodule

// ===== tb/sv/periodic_timed_event_queue_tb.sv =====
// Testbench for the timed event queue: random and directed commands, scoreboard checking
module periodic_timed_event_queue_tb;
    import pteq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                 fv;
        logic [ID_BITS-1:0]   id;
        logic                 fnd;
        logic                 ovf;
        logic                 lst;
    } t_outcome;

    class queue_scoreboard;
        logic [TIME_BITS-1:0] now;
        bit                   used[SLOTS];
        logic [ID_BITS-1:0]   sid[SLOTS];
        logic [TIME_BITS-1:0] due[SLOTS];
        logic [TIME_BITS-1:0] reload[SLOTS];
        t_outcome             pending[$];
        int                   errors;

        function new();
            now = '0;
            errors = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function int earliest_slot(bit only_due, bit match, logic [ID_BITS-1:0] id);
            int best;
            best = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!used[i]) continue;
                if (match && sid[i] != id) continue;
                if (only_due && due[i] > now) continue;
                if (best < 0 || due[i] < due[best]) best = i;
            end
            return best;
        endfunction

        function void note_command(t_cmd cmd, logic [ID_BITS-1:0] id,
                                   logic [TIME_BITS-1:0] t, logic [TIME_BITS-1:0] iv);
            t_outcome o;
            int s;
            int n;
            o = '0;
            o.lst = 1;
            case (cmd)
                CMD_TICK: begin
                    now = now + 1;
                    n = 0;
                    while (n < MAX_FIRES) begin
                        s = earliest_slot(1, 0, '0);
                        if (s < 0) break;
                        pending.push_back('{1'b1, sid[s], 1'b0, 1'b0, 1'b0});
                        n++;
                        if (reload[s] != 0) due[s] = due[s] + reload[s];
                        else used[s] = 0;
                    end
                    if (n == 0) pending.push_back(o);
                    else pending[$].lst = 1;
                end
                CMD_SCHED: begin
                    if (id != 0) begin
                        s = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (!used[i] && s < 0) s = i;
                        if (s < 0) o.ovf = 1;
                        else begin
                            used[s] = 1;
                            sid[s] = id;
                            due[s] = t;
                            reload[s] = iv;
                        end
                    end
                    pending.push_back(o);
                end
                CMD_CHECK: begin
                    if (id != 0 && earliest_slot(0, 1, id) >= 0) o.fnd = 1;
                    pending.push_back(o);
                end
                default: begin
                    if (id != 0) begin
                        s = earliest_slot(0, 1, id);
                        if (s >= 0) used[s] = 0;
                    end
                    pending.push_back(o);
                end
            endcase
        endfunction

        function void check_result(t_outcome got);
            t_outcome w;
            if (pending.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.fv !== w.fv) begin
                $error("fired_valid exp %0d got %0d", w.fv, got.fv); errors++;
            end
            if (got.id !== w.id) begin
                $error("fired_id exp %0d got %0d", w.id, got.id); errors++;
            end
            if (got.fnd !== w.fnd) begin
                $error("found exp %0d got %0d", w.fnd, got.fnd); errors++;
            end
            if (got.ovf !== w.ovf) begin
                $error("overflow exp %0d got %0d", w.ovf, got.ovf); errors++;
            end
            if (got.lst !== w.lst) begin
                $error("last exp %0d got %0d", w.lst, got.lst); errors++;
            end
        endfunction
    endclass

    localparam int WATCHDOG = 200000;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_start = 0;
    logic                 o_busy;
    logic [1:0]           i_command = '0;
    logic [ID_BITS-1:0]   i_event_id = '0;
    logic [TIME_BITS-1:0] i_event_time = '0;
    logic [TIME_BITS-1:0] i_event_interval = '0;
    logic                 o_strobe;
    logic                 o_fired_valid;
    logic [ID_BITS-1:0]   o_fired_id;
    logic                 o_found;
    logic                 o_overflow;
    logic                 o_last;

    queue_scoreboard sb = new();
    int idle_pct = 20;
    int stall_cnt = 0;

    periodic_timed_event_queue u_top (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe)
                sb.check_result('{o_fired_valid, o_fired_id, o_found, o_overflow, o_last});
            if (o_strobe || (i_start && !o_busy)) stall_cnt <= 0;
            else stall_cnt <= stall_cnt + 1;
            if (stall_cnt > WATCHDOG) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // returns at an edge where the block is idle, so the next command may be driven at once
    task automatic send_cmd(t_cmd cmd, logic [ID_BITS-1:0] id,
                            logic [TIME_BITS-1:0] t, logic [TIME_BITS-1:0] iv);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        i_start <= 1;
        i_command <= cmd;
        i_event_id <= id;
        i_event_time <= t;
        i_event_interval <= iv;
        do @(posedge i_clk); while (o_busy);
        sb.note_command(cmd, id, t, iv);
        i_start <= 0;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic random_cmd();
        int r;
        logic [ID_BITS-1:0] id;
        logic [TIME_BITS-1:0] t;
        logic [TIME_BITS-1:0] iv;
        r = $urandom_range(99);
        id = ($urandom_range(9) == 0) ? ID_BITS'($urandom) : ID_BITS'($urandom_range(6));
        t = ($urandom_range(7) == 0) ? $urandom : sb.now + TIME_BITS'($urandom_range(8));
        case ($urandom_range(5))
            0: iv = 0;
            1: iv = $urandom;
            2: iv = 32'hFFFF_FFFF - $urandom_range(3);
            default: iv = TIME_BITS'($urandom_range(6));
        endcase
        if (r < 40) send_cmd(CMD_TICK, ID_BITS'($urandom), $urandom, $urandom);
        else if (r < 70) send_cmd(CMD_SCHED, id, t, iv);
        else if (r < 85) send_cmd(CMD_CHECK, id, $urandom, $urandom);
        else send_cmd(CMD_REMOVE, id, $urandom, $urandom);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: zero id, extremes, ties, wrapping reload, full table
        send_cmd(CMD_TICK, '0, '0, '0);
        send_cmd(CMD_SCHED, '0, 32'd0, 32'd0);
        send_cmd(CMD_CHECK, '0, '0, '0);
        send_cmd(CMD_REMOVE, '0, '0, '0);
        send_cmd(CMD_SCHED, 16'hFFFF, 32'd0, 32'd0);
        send_cmd(CMD_SCHED, 16'h0001, 32'd0, 32'hFFFF_FFFF);
        send_cmd(CMD_SCHED, 16'h0002, 32'd2, 32'd1);
        send_cmd(CMD_CHECK, 16'hFFFF, '0, '0);
        send_cmd(CMD_TICK, '0, '0, '0);
        send_cmd(CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_REMOVE, 16'h0002, '0, '0);
        send_cmd(CMD_CHECK, 16'h0002, '0, '0);
        for (int i = 0; i < SLOTS + 1; i++)
            send_cmd(CMD_SCHED, 16'h0010 + i[15:0], 32'hFFFF_FFFF, 32'd0);
        send_cmd(CMD_REMOVE, 16'h0001, '0, '0);
        send_cmd(CMD_SCHED, 16'h0003, 32'd0, 32'd1);
        send_cmd(CMD_TICK, '0, '0, '0);
        for (int i = 0; i < SLOTS + 1; i++)
            send_cmd(CMD_REMOVE, 16'h0010 + i[15:0], '0, '0);
        send_cmd(CMD_REMOVE, 16'h0003, '0, '0);
        send_cmd(CMD_REMOVE, 16'hFFFF, '0, '0);
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 20 : (ph == 1) ? 61 : 0;
            for (int k = 0; k < 135; k++) random_cmd();
        end
        while (sb.pending.size() != 0 && stall_cnt < WATCHDOG) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
